// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check of a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/umrpm_pkg.sv =====
package umrpm_pkg;

    localparam int DELTA_W  = 16;
    localparam int WHEEL_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int BTN_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CNT_W    = 5;

    localparam logic [CNT_W-1:0] LONG_STEPS  = CNT_W'(DELTA_W);
    localparam logic [CNT_W-1:0] SHORT_STEPS = CNT_W'(WHEEL_W);

    localparam logic [BYTE_W-1:0] XOR_BTN    = 8'hAE;
    localparam logic [BYTE_W-1:0] XOR_X      = 8'hEA;
    localparam logic [BYTE_W-1:0] XOR_Y      = 8'h77;
    localparam logic [BYTE_W-1:0] WHEEL_MASK = 8'hF0;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_DIV    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_INV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_DIV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_SWAP = 3'd4;

    localparam logic OP_MOUSE    = 1'b0;
    localparam logic OP_KEYBOARD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DIV_W,
        ST_LOAD
    } umrpm_state_t;

    typedef struct packed {
        logic go;
        logic short_op;
    } umrpm_div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } umrpm_div_stat_t;

endpackage

// ===== rtl/usb_mouse_to_retro_port_mapper.sv =====
// Maps mouse and keyboard-chord items onto a three-byte retro mouse port.
// A keyboard item is taken whenever the block is idle and gives no result. A
// mouse item passes through the single serial divider, which produces one
// quotient bit per cycle: 16 steps each for X and Y, 8 for the wheel. After the
// wheel division the result is loaded into the output register, which waits
// while a held result is stalled; the next item is taken once the block is idle
// again. in_stall is high for the whole of that time.
module usb_mouse_to_retro_port_mapper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [umrpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [umrpm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic signed [umrpm_pkg::DELTA_W-1:0] delta_x,
    input  logic signed [umrpm_pkg::DELTA_W-1:0] delta_y,
    input  logic signed [umrpm_pkg::WHEEL_W-1:0] wheel_delta,
    input  logic [umrpm_pkg::BTN_W-1:0]         button_bits,
    input  logic                                chord_pressed,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [umrpm_pkg::BYTE_W-1:0]        port_buttons_wheel,
    output logic [umrpm_pkg::BYTE_W-1:0]        port_x,
    output logic [umrpm_pkg::BYTE_W-1:0]        port_y
);
    import umrpm_pkg::*;

    umrpm_state_t state_reg, state_next;

    logic [BYTE_W-1:0]  axis_div_reg;
    logic               wheel_en_reg;
    logic               wheel_inv_reg;
    logic [BYTE_W-1:0]  wheel_div_reg;
    logic               button_swap_reg;
    logic               session_swap_reg, session_swap_next;
    logic               prev_chord_reg, prev_chord_next;

    logic [DELTA_W-1:0] y_reg;
    logic [WHEEL_W-1:0] w_reg;
    logic [BTN_W-1:0]   btn_reg;
    logic [BYTE_W-1:0]  qx_reg;
    logic [BYTE_W-1:0]  qy_reg;
    logic [BYTE_W-1:0]  qw_reg;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  bw_reg;
    logic [BYTE_W-1:0]  px_reg;
    logic [BYTE_W-1:0]  py_reg;

    logic               in_take;
    logic               mouse_take;
    logic               out_load;
    logic [WHEEL_W-1:0] w_en;
    logic [WHEEL_W-1:0] w_proc;
    logic [BTN_W-1:0]   btn_sw;

    umrpm_div_cmd_t     div_cmd;
    umrpm_div_stat_t    div_stat;
    logic signed [DELTA_W-1:0] div_dividend;
    logic [BYTE_W-1:0]  div_divisor;
    logic [BYTE_W-1:0]  div_quotient;

    umrpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_div_reg    <= BYTE_W'(1);
            wheel_en_reg    <= 1'b1;
            wheel_inv_reg   <= 1'b0;
            wheel_div_reg   <= BYTE_W'(1);
            button_swap_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_AXIS_DIV:    axis_div_reg    <= cfg_data;
                CFG_WHEEL_EN:    wheel_en_reg    <= cfg_data[0];
                CFG_WHEEL_INV:   wheel_inv_reg   <= cfg_data[0];
                CFG_WHEEL_DIV:   wheel_div_reg   <= cfg_data;
                CFG_BUTTON_SWAP: button_swap_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        in_take    = in_valid && !in_stall;
        mouse_take = in_take && (operation == OP_MOUSE);
        w_en       = wheel_en_reg ? wheel_delta : '0;
        w_proc     = wheel_inv_reg ? WHEEL_W'(-w_en) : w_en;
        btn_sw     = (button_swap_reg || session_swap_reg)
                     ? {button_bits[2], button_bits[0], button_bits[1]} : button_bits;
    end

    always_comb
    begin
        state_next        = state_reg;
        session_swap_next = session_swap_reg;
        prev_chord_next   = prev_chord_reg;
        out_load          = 1'b0;
        div_cmd.go        = 1'b0;
        div_cmd.short_op  = 1'b0;
        div_dividend      = delta_x;
        div_divisor       = axis_div_reg;
        in_stall          = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && operation == OP_KEYBOARD)
                begin
                    if (chord_pressed && !prev_chord_reg)
                    begin
                        session_swap_next = !session_swap_reg;
                    end
                    prev_chord_next = chord_pressed;
                end
                if (mouse_take)
                begin
                    div_cmd.go = 1'b1;
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                div_dividend = y_reg;
                if (div_stat.done)
                begin
                    div_cmd.go = 1'b1;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                div_dividend     = DELTA_W'(signed'(w_reg));
                div_divisor      = wheel_div_reg;
                div_cmd.short_op = 1'b1;
                if (div_stat.done)
                begin
                    div_cmd.go = 1'b1;
                    state_next = ST_DIV_W;
                end
            end
            ST_DIV_W:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            session_swap_reg <= 1'b0;
            prev_chord_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            session_swap_reg <= session_swap_next;
            prev_chord_reg   <= prev_chord_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mouse_take)
        begin
            y_reg   <= delta_y;
            w_reg   <= w_proc;
            btn_reg <= btn_sw;
        end
        if (div_stat.done && state_reg == ST_DIV_X)
        begin
            qx_reg <= div_quotient;
        end
        if (div_stat.done && state_reg == ST_DIV_Y)
        begin
            qy_reg <= div_quotient;
        end
        if (div_stat.done && state_reg == ST_DIV_W)
        begin
            qw_reg <= div_quotient;
        end
        if (out_load)
        begin
            bw_reg <= (({qw_reg[3:0], 4'h0} & WHEEL_MASK) | {4'h0, 1'b1, ~btn_reg}) ^ XOR_BTN;
            px_reg <= qx_reg ^ XOR_X;
            py_reg <= qy_reg ^ XOR_Y;
        end
    end

    assign out_valid          = out_valid_reg;
    assign port_buttons_wheel = bw_reg;
    assign port_x             = px_reg;
    assign port_y             = py_reg;

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_idle_div_quiet, state_reg == ST_IDLE, !div_stat.busy && !div_stat.done,
        "divider active while sequencer idle")
    `ASSERT_IMPLIES(a_done_in_div, div_stat.done,
        state_reg == ST_DIV_X || state_reg == ST_DIV_Y || state_reg == ST_DIV_W,
        "divider done outside a division step")
    `ASSERT_IMPLIES(a_out_rise_from_load, $rose(out_valid_reg), $past(state_reg) == ST_LOAD,
        "result appeared without a load step")
    `ASSERT_NEXT(a_kbd_no_work, in_take && operation == OP_KEYBOARD,
        state_reg == ST_IDLE && !div_stat.busy,
        "keyboard item started work")

endmodule

// ===== rtl/umrpm_div.sv =====
module umrpm_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  umrpm_pkg::umrpm_div_cmd_t        cmd,
    input  logic signed [umrpm_pkg::DELTA_W-1:0] dividend,
    input  logic [umrpm_pkg::BYTE_W-1:0]     divisor,
    output umrpm_pkg::umrpm_div_stat_t       stat,
    output logic [umrpm_pkg::BYTE_W-1:0]     quotient
);
    import umrpm_pkg::*;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [DELTA_W-1:0] mag_reg;
    logic [BYTE_W-1:0]  rem_reg;
    logic [BYTE_W-1:0]  dvs_reg;
    logic               neg_reg;

    logic [BYTE_W:0]    trial;
    logic [BYTE_W:0]    diff;
    logic               fits;
    logic [DELTA_W-1:0] abs_long;
    logic [WHEEL_W-1:0] abs_short;

    always_comb
    begin
        trial     = {rem_reg, mag_reg[DELTA_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = trial >= {1'b0, dvs_reg};
        abs_long  = dividend[DELTA_W-1] ? DELTA_W'(-dividend) : DELTA_W'(dividend);
        abs_short = dividend[WHEEL_W-1] ? WHEEL_W'(-dividend[WHEEL_W-1:0])
                                        : dividend[WHEEL_W-1:0];
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.go)
        begin
            cnt_next = cmd.short_op ? SHORT_STEPS : LONG_STEPS;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            rem_reg <= '0;
            dvs_reg <= (divisor == '0) ? BYTE_W'(1) : divisor;
            if (cmd.short_op)
            begin
                neg_reg <= dividend[WHEEL_W-1];
                mag_reg <= {abs_short, {(DELTA_W-WHEEL_W){1'b0}}};
            end
            else
            begin
                neg_reg <= dividend[DELTA_W-1];
                mag_reg <= abs_long;
            end
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[BYTE_W-1:0] : trial[BYTE_W-1:0];
            mag_reg <= {mag_reg[DELTA_W-2:0], fits};
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? BYTE_W'(-mag_reg[BYTE_W-1:0]) : mag_reg[BYTE_W-1:0];

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import umrpm_pkg::*;

    localparam int SETTLE_CYCLES = 60;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 200;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SCRIPT_ROWS   = 32;

    typedef struct packed {
        logic               op;
        logic [DELTA_W-1:0] dx;
        logic [DELTA_W-1:0] dy;
        logic [WHEEL_W-1:0] wheel;
        logic [BTN_W-1:0]   btn;
        logic               chord;
    } report_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] buttons_wheel;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
    } port_bytes_t;

    typedef enum bit {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        report_item_t          item;
        bit                    typed;
        port_bytes_t           want;
    } script_row_t;

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index     = CFG_AXIS_DIV;
    logic [CFG_DATA_W-1:0]        cfg_data      = '0;
    logic                         in_valid      = 1'b0;
    logic                         in_stall;
    logic                         operation     = OP_MOUSE;
    logic signed [DELTA_W-1:0]    delta_x       = '0;
    logic signed [DELTA_W-1:0]    delta_y       = '0;
    logic signed [WHEEL_W-1:0]    wheel_delta   = '0;
    logic [BTN_W-1:0]             button_bits   = '0;
    logic                         chord_pressed = 1'b0;
    logic                         out_valid;
    logic                         out_stall     = 1'b0;
    logic [BYTE_W-1:0]            port_buttons_wheel;
    logic [BYTE_W-1:0]            port_x;
    logic [BYTE_W-1:0]            port_y;

    logic [CFG_DATA_W-1:0] axis_div     = 8'd1;
    logic                  wheel_on     = 1'b1;
    logic                  wheel_neg    = 1'b0;
    logic [CFG_DATA_W-1:0] wheel_div    = 8'd1;
    logic                  swap_fixed   = 1'b0;
    logic                  session_swap = 1'b0;
    logic                  prev_chord   = 1'b0;

    port_bytes_t expected_ports[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          calm           = 1'b0;
    int          stall_left     = 0;
    int          run_left       = 0;

    script_row_t script [SCRIPT_ROWS] = '{
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h0000, 16'h0000, 8'h00, 3'd0, 1'b0}, 1'b1, '{8'hA1, 8'hEA, 8'h77}},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h7FFF, 16'h8000, 8'h7F, 3'd7, 1'b0}, 1'b1, '{8'h56, 8'h15, 8'h77}},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h8000, 16'h7FFF, 8'h80, 3'd0, 1'b1}, 1'b1, '{8'hA1, 8'hEA, 8'h88}},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'hFFFF, 16'h0001, 8'hFF, 3'd1, 1'b0}, 1'b1, '{8'h50, 8'h15, 8'h76}},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h0000, 16'h0000, 8'h00, 3'd2, 1'b0}, 1'b1, '{8'hA3, 8'hEA, 8'h77}},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_KEYBOARD, 16'h5A5A, 16'hA5A5, 8'hC3, 3'd5, 1'b1}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h0010, 16'hFFF0, 8'h02, 3'd1, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_KEYBOARD, 16'h0000, 16'h0000, 8'h00, 3'd0, 1'b1}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h0000, 16'h0000, 8'h00, 3'd2, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_KEYBOARD, 16'hFFFF, 16'hFFFF, 8'hFF, 3'd7, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_KEYBOARD, 16'h0000, 16'h0000, 8'h00, 3'd0, 1'b1}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h0000, 16'h0000, 8'h00, 3'd5, 1'b0}, 1'b0, '0},
        '{ROW_CFG, CFG_WHEEL_INV, 8'h01, '0, 1'b0, '0},
        '{ROW_CFG, CFG_WHEEL_DIV, 8'h00, '0, 1'b0, '0},
        '{ROW_CFG, CFG_AXIS_DIV, 8'h00, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h8000, 16'h7FFF, 8'h80, 3'd3, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h7FFF, 16'h8000, 8'h7F, 3'd4, 1'b0}, 1'b0, '0},
        '{ROW_CFG, CFG_AXIS_DIV, 8'hFF, '0, 1'b0, '0},
        '{ROW_CFG, CFG_WHEEL_DIV, 8'hFF, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h7FFF, 16'h8000, 8'h80, 3'd3, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'hFF01, 16'h00FF, 8'h01, 3'd6, 1'b0}, 1'b0, '0},
        '{ROW_CFG, CFG_WHEEL_INV, 8'h00, '0, 1'b0, '0},
        '{ROW_CFG, CFG_WHEEL_DIV, 8'h03, '0, 1'b0, '0},
        '{ROW_CFG, CFG_AXIS_DIV, 8'h07, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'hFF9C, 16'h0064, 8'hF9, 3'd6, 1'b0}, 1'b0, '0},
        '{ROW_CFG, CFG_WHEEL_EN, 8'hFE, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h1234, 16'hEDCC, 8'h7F, 3'd7, 1'b0}, 1'b0, '0},
        '{ROW_CFG, CFG_BUTTON_SWAP, 8'h01, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h0000, 16'h0000, 8'h00, 3'd1, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_KEYBOARD, 16'h0000, 16'h0000, 8'h00, 3'd0, 1'b0}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_KEYBOARD, 16'h0000, 16'h0000, 8'h00, 3'd0, 1'b1}, 1'b0, '0},
        '{ROW_ITEM, CFG_AXIS_DIV, 8'h00,
          '{OP_MOUSE, 16'h0000, 16'h0000, 8'h00, 3'd2, 1'b0}, 1'b0, '0}
    };

    usb_mouse_to_retro_port_mapper u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .operation          (operation),
        .delta_x            (delta_x),
        .delta_y            (delta_y),
        .wheel_delta        (wheel_delta),
        .button_bits        (button_bits),
        .chord_pressed      (chord_pressed),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .port_buttons_wheel (port_buttons_wheel),
        .port_x             (port_x),
        .port_y             (port_y)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int idle_len();
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 16);
        return $urandom_range(40, 200);
    endfunction

    // Advance the chord state or scale one mouse report into port bytes.
    function automatic bit map_report(input report_item_t it, output port_bytes_t ports);
        int               axis_d;
        int               wheel_d;
        int               mx;
        int               my;
        int               w;
        logic [BTN_W-1:0] b;
        ports = '0;
        if (it.op == OP_KEYBOARD)
        begin
            if (it.chord && !prev_chord)
                session_swap = ~session_swap;
            prev_chord = it.chord;
            return 1'b0;
        end
        axis_d  = (axis_div == 0) ? 1 : int'(axis_div);
        wheel_d = (wheel_div == 0) ? 1 : int'(wheel_div);
        mx = int'($signed(it.dx)) / axis_d;
        my = int'($signed(it.dy)) / axis_d;
        w  = wheel_on ? int'($signed(it.wheel)) : 0;
        if (wheel_neg)
        begin
            w = -w;
            if (w == 128)
                w = -128;
        end
        w = w / wheel_d;
        b = it.btn;
        if (swap_fixed || session_swap)
            b = {b[2], b[0], b[1]};
        ports.buttons_wheel = {w[3:0], 1'b1, ~b} ^ XOR_BTN;
        ports.x = mx[7:0] ^ XOR_X;
        ports.y = my[7:0] ^ XOR_Y;
        return 1'b1;
    endfunction

    function automatic logic [DELTA_W-1:0] pick_delta();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [WHEEL_W-1:0] pick_wheel();
        case ($urandom_range(0, 7))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic report_item_t random_report();
        report_item_t it;
        it.op    = ($urandom_range(0, 4) == 0) ? OP_KEYBOARD : OP_MOUSE;
        it.dx    = pick_delta();
        it.dy    = pick_delta();
        it.wheel = pick_wheel();
        it.btn   = BTN_W'($urandom_range(0, 7));
        it.chord = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_AXIS_DIV:    axis_div   = value;
            CFG_WHEEL_EN:    wheel_on   = value[0];
            CFG_WHEEL_INV:   wheel_neg  = value[0];
            CFG_WHEEL_DIV:   wheel_div  = value;
            CFG_BUTTON_SWAP: swap_fixed = value[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every pending result, then let the block settle.
    task automatic wait_for_idle(input int extra);
        in_valid <= 1'b0;
        while (expected_ports.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic send_report(input report_item_t it, input bit typed,
                               input port_bytes_t want);
        port_bytes_t predicted;
        int          gap;
        in_valid      <= 1'b1;
        operation     <= it.op;
        delta_x       <= it.dx;
        delta_y       <= it.dy;
        wheel_delta   <= it.wheel;
        button_bits   <= it.btn;
        chord_pressed <= it.chord;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (map_report(it, predicted))
            expected_ports.push_back(typed ? want : predicted);
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        port_bytes_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_ports.size() == 0)
                begin
                    $error("unexpected item: port_buttons_wheel %h port_x %h port_y %h",
                           port_buttons_wheel, port_x, port_y);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_ports.pop_front();
                    if (port_buttons_wheel !== want.buttons_wheel)
                    begin
                        $error("port_buttons_wheel: expected %h, actual %h",
                               want.buttons_wheel, port_buttons_wheel);
                        mismatch_count++;
                    end
                    if (port_x !== want.x)
                    begin
                        $error("port_x: expected %h, actual %h", want.x, port_x);
                        mismatch_count++;
                    end
                    if (port_y !== want.y)
                    begin
                        $error("port_y: expected %h, actual %h", want.y, port_y);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
                else
                begin
                    stall_left = idle_len();
                    run_left   = $urandom_range(0, 6);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] axis_v;
        logic [CFG_DATA_W-1:0] en_v;
        logic [CFG_DATA_W-1:0] inv_v;
        logic [CFG_DATA_W-1:0] wdiv_v;
        logic [CFG_DATA_W-1:0] swap_v;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            if (script[r].kind == ROW_CFG)
            begin
                wait_for_idle(SETTLE_CYCLES);
                write_reg(script[r].idx, script[r].data);
            end
            else
                send_report(script[r].item, script[r].typed, script[r].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            calm = 1'b0;
            wait_for_idle(SETTLE_CYCLES);
            case (p)
                0:
                begin
                    axis_v = 8'd1; en_v = 8'd1; inv_v = 8'd0; wdiv_v = 8'd1; swap_v = 8'd0;
                end
                1:
                begin
                    axis_v = 8'hFF; en_v = 8'hFF; inv_v = 8'hFF; wdiv_v = 8'hFF; swap_v = 8'hFF;
                end
                2:
                begin
                    axis_v = 8'h00; en_v = 8'hFE; inv_v = 8'h00; wdiv_v = 8'h00; swap_v = 8'hFE;
                end
                default:
                begin
                    axis_v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(1, 12));
                    en_v   = 8'($urandom);
                    inv_v  = 8'($urandom);
                    wdiv_v = 8'($urandom_range(0, 6));
                    swap_v = 8'($urandom);
                end
            endcase
            write_reg(CFG_AXIS_DIV, axis_v);
            write_reg(CFG_WHEEL_EN, en_v);
            write_reg(CFG_WHEEL_INV, inv_v);
            write_reg(CFG_WHEEL_DIV, wdiv_v);
            write_reg(CFG_BUTTON_SWAP, swap_v);
            calm = (p == 3) || (p == 6);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_for_idle(1);
                send_report(random_report(), 1'b0, '0);
            end
        end

        calm = 1'b0;
        wait_for_idle(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/umrpm_pkg.sv
rtl/umrpm_div.sv
rtl/usb_mouse_to_retro_port_mapper.sv
tb/sv/tb_top.sv
